/* design/lfcr_pkg.sv */
// Shared types, constants and the 5x7 font ROM for the LCD character renderer.
package lfcr_pkg;

  localparam int unsigned GlyphCols = 5;
  localparam int unsigned GlyphIdxW = 7;

  localparam logic [7:0] FirstCode   = 8'h20;
  localparam logic [7:0] LastCode    = 8'h7A;
  localparam logic [7:0] CheckerCode = 8'h5C;
  localparam logic [7:0] CmdColumn   = 8'h80;
  localparam logic [7:0] CmdRow      = 8'h40;

  typedef logic [0:GlyphCols-1][7:0] glyph_t;

  // One character, glyph fetched, ready for shifting out
  typedef struct packed {
    glyph_t     glyph;
    logic       start;
    logic [7:0] col_pos;
    logic [2:0] row;
    logic       inv;
    logic       big_en;
    logic       upper;
  } lfcr_item_t;

  // Columns listed left to right; entry n is code 0x20 + n
  function automatic glyph_t glyph_rom(input logic [GlyphIdxW-1:0] idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00002f0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h242a7f2a12;
      7'd5:  g = 40'hc4c8102646;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001c224100;
      7'd9:  g = 40'h0041221c00;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0000503000;
      7'd13: g = 40'h1010101010;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3e5149453e;
      7'd17: g = 40'h00427f4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454b31;
      7'd20: g = 40'h1814127f10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3c4a494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291e;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324959513e;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h7f49494936;
      7'd35: g = 40'h3e41414122;
      7'd36: g = 40'h7f4141221c;
      7'd37: g = 40'h7f49494941;
      7'd38: g = 40'h7f09090901;
      7'd39: g = 40'h3e4149497a;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h2040413f01;
      7'd43: g = 40'h7f08142241;
      7'd44: g = 40'h7f40404040;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f0408107f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h7f09090906;
      7'd49: g = 40'h3e4151215e;
      7'd50: g = 40'h7f09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007f414100;
      7'd60: g = 40'h552a552a55;
      7'd61: g = 40'h0041417f00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7f48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487f;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087e090102;
      7'd71: g = 40'h0c5252523e;
      7'd72: g = 40'h7f08040478;
      7'd73: g = 40'h00447d4000;
      7'd74: g = 40'h2040443d00;
      7'd75: g = 40'h7f10284400;
      7'd76: g = 40'h00417f4000;
      7'd77: g = 40'h7c04180478;
      7'd78: g = 40'h7c08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7c14141408;
      7'd81: g = 40'h081414187c;
      7'd82: g = 40'h7c08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043f444020;
      7'd85: g = 40'h3c4040207c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0c5050503c;
      7'd90: g = 40'h4464544c44;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* design/lfcr_serializer.sv */
// Output stage: shifts one rendered character out as command and data bytes.
module lfcr_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfcr_pkg::lfcr_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_cmd_o,
  output logic                out_last_o
);
  import lfcr_pkg::*;

  localparam logic [3:0] SlotColumn = 4'd0;
  localparam logic [3:0] SlotRow    = 4'd1;
  localparam logic [3:0] SlotData   = 4'd2;
  localparam logic [3:0] EndNormal  = 4'd7;
  localparam logic [3:0] EndBig     = 4'd13;

  function automatic logic [7:0] widen(input logic [3:0] nib);
    return {{2{nib[3]}}, {2{nib[2]}}, {2{nib[1]}}, {2{nib[0]}}};
  endfunction

  logic       busy_q, busy_d;
  logic [3:0] slot_q, slot_d;
  lfcr_item_t item_q;

  logic       load, xfer, last;
  logic [3:0] dslot;
  logic [2:0] colsel;
  logic [7:0] raw, pix;

  assign last        = (slot_q == (item_q.big_en ? EndBig : EndNormal));
  assign xfer        = busy_q && out_ready_i;
  assign in_ready_o  = !busy_q || (out_ready_i && last);
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = busy_q;
  assign out_last_o  = last;

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (load) begin
      busy_d = 1'b1;
      slot_d = in_item_i.start ? SlotColumn : SlotData;
    end else if (xfer) begin
      if (last) begin
        busy_d = 1'b0;
      end
      slot_d = slot_q + 4'd1;
    end
  end

  // Big mode sends each column twice, so two slots share one column
  always_comb begin
    dslot  = slot_q - SlotData;
    colsel = item_q.big_en ? dslot[3:1] : dslot[2:0];
    raw    = (colsel < 3'(GlyphCols)) ? item_q.glyph[colsel] : 8'h00;
    pix    = item_q.big_en ? widen(item_q.upper ? raw[3:0] : raw[7:4]) : raw;
    out_cmd_o = 1'b0;
    if (slot_q == SlotColumn) begin
      out_byte_o = CmdColumn | item_q.col_pos;
      out_cmd_o  = 1'b1;
    end else if (slot_q == SlotRow) begin
      out_byte_o = CmdRow | {5'd0, item_q.row};
      out_cmd_o  = 1'b1;
    end else begin
      out_byte_o = pix ^ {8{item_q.inv}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= SlotColumn;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

endmodule

/* design/lcd_font_character_renderer.sv */
// Top level of the 5x7 font LCD character renderer: decode, font fetch, shift-out.
//
//  channel  dir  handshake              contents
//  s_axis   in   s_axis_tvalid/tready   one character with its display options
//  m_axis   out  m_axis_tvalid/tready   one command or display byte per transfer
//
// Three register stages: code decode and column sum, font ROM fetch, shift-out.
// A character gives 6 or 12 bytes, plus 2 commands at string start, one a cycle
// while m_axis is ready; the shift-out stage takes the next character with the last byte.
// While the shift-out stage is busy, decode and fetch hold up to two more characters.
// Reset empties all stages. A stall on m_axis holds the byte and backs up the stages.
module lcd_font_character_renderer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_code, [8] start_of_string, [12:9] text_column, [18:13] pixel_offset,
  // [21:19] text_row, [22] inverse, [24:23] big_half, [31:25] zero
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] byte_value
  output logic        m_axis_tuser_o,  // [0] is_command
  output logic        m_axis_tlast_o
);
  import lfcr_pkg::*;

  typedef struct packed {
    logic [GlyphIdxW-1:0] idx;
    logic                 start;
    logic [7:0]           col_pos;
    logic [2:0]           row;
    logic                 inv;
    logic                 big_en;
    logic                 upper;
  } dec_t;

  logic       v1_q, v1_d, v2_q, v2_d;
  dec_t       s1_q, s1_d;
  lfcr_item_t s2_q, s2_d;
  logic       take1, take2, ser_ready;

  logic [7:0] code, code_n;
  logic [3:0] col;
  logic [5:0] off;
  logic [1:0] big;

  assign code = s_axis_tdata_i[7:0];
  assign col  = s_axis_tdata_i[12:9];
  assign off  = s_axis_tdata_i[18:13];
  assign big  = s_axis_tdata_i[24:23];

  assign take2           = !v2_q || ser_ready;
  assign take1           = !v1_q || take2;
  assign s_axis_tready_o = take1;

  always_comb begin
    if (code == 8'h00) begin
      code_n = FirstCode;
    end else if (code < FirstCode || code > LastCode) begin
      code_n = CheckerCode;
    end else begin
      code_n = code;
    end
    s1_d.idx     = GlyphIdxW'(code_n - FirstCode);
    s1_d.start   = s_axis_tdata_i[8];
    s1_d.col_pos = {2'b00, col, 2'b00} + {3'b000, col, 1'b0} + {2'b00, off};
    s1_d.row     = s_axis_tdata_i[21:19];
    s1_d.inv     = s_axis_tdata_i[22];
    s1_d.big_en  = (big != 2'd0);
    s1_d.upper   = big[0];  // 3 behaves as 1
  end

  always_comb begin
    s2_d.glyph   = glyph_rom(s1_q.idx);
    s2_d.start   = s1_q.start;
    s2_d.col_pos = s1_q.col_pos;
    s2_d.row     = s1_q.row;
    s2_d.inv     = s1_q.inv;
    s2_d.big_en  = s1_q.big_en;
    s2_d.upper   = s1_q.upper;
  end

  always_comb begin
    v1_d = take1 ? s_axis_tvalid_i : v1_q;
    v2_d = take2 ? v1_q : v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1 && s_axis_tvalid_i) begin
      s1_q <= s1_d;
    end
    if (take2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  lfcr_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_ready_o  (ser_ready),
    .in_item_i   (s2_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_cmd_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
